[hw/rtl/ohlc_pkg.sv]
// ohlc_pkg: shared types, constants and bar record layout for the ohlc bar aggregator
// no dependencies
package ohlc_pkg;

  localparam int PAIR_COUNT  = 64;
  localparam int NUM_PERIODS = 3;
  localparam int SLOTS       = PAIR_COUNT * NUM_PERIODS;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int PAIR_W      = 6;
  localparam int TIME_W      = 48;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] MINUTE_RESET = 32'd60000;
  localparam logic [31:0] HOUR_RESET   = 32'd3600000;
  localparam logic [31:0] DAY_RESET    = 32'd86400000;

  localparam logic [1:0] REG_MINUTE = 2'd0;
  localparam logic [1:0] REG_HOUR   = 2'd1;
  localparam logic [1:0] REG_DAY    = 2'd2;

  localparam logic [1:0] PER_MINUTE = 2'd0;
  localparam logic [1:0] PER_HOUR   = 2'd1;
  localparam logic [1:0] PER_DAY    = 2'd2;

  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic [31:0]       price;
    logic [31:0]       qty;
    logic [TIME_W-1:0] t;
  } trade_t;

  // stored bar record
  typedef struct packed {
    logic [TIME_W-1:0] begin_t;
    logic [31:0]       open_p;
    logic [31:0]       high_p;
    logic [31:0]       low_p;
    logic [31:0]       close_p;
    logic [63:0]       amount;
    logic [63:0]       volume;
    logic [31:0]       count;
  } bar_t;

  localparam int BAR_W = $bits(bar_t);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_MUL, ST_ALIGN, ST_WRITE
  } bk_state_t;

endpackage

[hw/rtl/ohlc_ram.sv]
// ohlc_ram: generic single-port-write, registered-read ram
// no dependencies
module ohlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/ohlc_front.sv]
// ohlc_front: accepts trades, drops out-of-range pairs, queues the rest
// depends on ohlc_pkg
module ohlc_front import ohlc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  trade_t trade,
  output logic   busy,
  output logic   q_valid,
  output trade_t q_data,
  input  logic   q_pop
);
  trade_t                       q_r [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH):0] cnt_r, cnt_nxt;
  logic                         push;

  assign busy    = (cnt_r == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
  assign push    = start && !busy && (32'(trade.pair) < PAIR_COUNT);
  assign q_valid = (cnt_r != '0);
  assign q_data  = q_r[0];

  always_comb begin
    cnt_nxt = cnt_r + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  // shift queue: head at entry 0
  always_ff @(posedge clk) begin
    if (push && (cnt_r == '0 || (q_pop && cnt_r == 2'd1))) q_r[0] <= trade;
    else if (q_pop) q_r[0] <= q_r[1];
    if (push && !q_pop && cnt_r == 2'd1) q_r[1] <= trade;
  end
endmodule

[hw/rtl/ohlc_div.sv]
// ohlc_div: bit-serial 48 by 32 remainder for first-bar alignment
// depends on ohlc_pkg
module ohlc_div import ohlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [TIME_W-1:0] num,
  input  logic [31:0]       den,
  output logic              done,
  output logic [31:0]       rem
);
  logic [TIME_W-1:0] n_r;
  logic [32:0]       rem_r;
  logic [5:0]        cnt_r;
  logic              run_r;
  logic [33:0]       sh;

  assign sh   = {rem_r, n_r[TIME_W-1]};
  assign done = run_r && (cnt_r == '0);
  assign rem  = rem_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (go) begin
      run_r <= 1'b1;
      cnt_r <= 6'(TIME_W);
    end else if (run_r) begin
      if (cnt_r == '0) run_r <= 1'b0;
      else cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_r   <= num;
      rem_r <= '0;
    end else if (run_r && cnt_r != '0) begin
      n_r <= n_r << 1;
      if (sh >= {2'b0, den}) rem_r <= 33'(sh - {2'b0, den});
      else rem_r <= sh[32:0];
    end
  end
endmodule

[hw/rtl/ohlc_back.sv]
// ohlc_back: read-modify-write of the three bars of a trade in the bar ram
// depends on ohlc_pkg, ohlc_ram, ohlc_div
module ohlc_back import ohlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  trade_t      q_data,
  output logic        q_pop,
  input  logic [31:0] len_min,
  input  logic [31:0] len_hour,
  input  logic [31:0] len_day,
  output logic        res_valid,
  output logic [1:0]  res_period,
  output logic [PAIR_W-1:0] res_pair,
  output bar_t        res_bar,
  output logic        res_new
);
  bk_state_t st_r, st_nxt;
  trade_t    tr_r;
  logic [1:0] per_r;
  logic [SLOTS-1:0] valid_r;
  logic [SLOT_W-1:0] slot;
  bar_t rd_bar, cur_r, nb;
  logic [63:0] prod_r;
  logic [31:0] len_sel;
  // one bit wider than a time stamp: the end of a late bar can pass the top
  logic [TIME_W:0] end_t;
  logic fold_r, newb, we, div_go, div_done;
  logic [31:0] rem;
  logic [TIME_W-1:0] nb_begin_r;

  assign slot = (SLOT_W'(tr_r.pair) * SLOT_W'(NUM_PERIODS)) + SLOT_W'(per_r);

  always_comb begin
    case (per_r)
      PER_MINUTE: len_sel = len_min;
      PER_HOUR:   len_sel = len_hour;
      default:    len_sel = len_day;
    endcase
    if (len_sel == '0) len_sel = 32'd1;
  end

  ohlc_ram #(.WIDTH(BAR_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(slot), .wdata(nb), .raddr(slot), .rdata(rd_bar)
  );

  ohlc_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(tr_r.t), .den(len_sel),
    .done(div_done), .rem(rem)
  );

  assign end_t = {1'b0, cur_r.begin_t} + (TIME_W+1)'(len_sel);

  // new record contents
  always_comb begin
    nb = cur_r;
    if (newb) begin
      nb.begin_t = nb_begin_r;
      nb.open_p  = tr_r.price;
      nb.high_p  = tr_r.price;
      nb.low_p   = tr_r.price;
      nb.close_p = tr_r.price;
      nb.amount  = prod_r;
      nb.volume  = 64'(tr_r.qty);
      nb.count   = 32'd1;
    end else begin
      if (cur_r.count != '1) nb.count = cur_r.count + 1'b1;
      nb.volume  = cur_r.volume + 64'(tr_r.qty);
      nb.amount  = cur_r.amount + prod_r;
      nb.close_p = tr_r.price;
      if (tr_r.price > cur_r.high_p) nb.high_p = tr_r.price;
      else if (tr_r.price < cur_r.low_p || cur_r.low_p == '0) nb.low_p = tr_r.price;
    end
  end
  assign newb = !fold_r;

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    we     = 1'b0;
    div_go = 1'b0;
    case (st_r)
      ST_IDLE:  if (q_valid) begin
        q_pop  = 1'b1;
        st_nxt = ST_READ;
      end
      ST_READ:  st_nxt = ST_CALC;
      ST_CALC:  if (valid_r[slot]) st_nxt = ST_MUL;
      else begin
        div_go = 1'b1;
        st_nxt = ST_ALIGN;
      end
      ST_ALIGN: if (div_done) st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_WRITE;
      ST_WRITE: begin
        we = 1'b1;
        if (per_r == PER_DAY) st_nxt = ST_IDLE;
        else st_nxt = ST_READ;
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      valid_r <= '0;
      per_r   <= PER_MINUTE;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE && q_valid) per_r <= PER_MINUTE;
      if (we) begin
        valid_r[slot] <= 1'b1;
        per_r <= per_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) tr_r <= q_data;
    case (st_r)
      ST_CALC: begin
        cur_r  <= rd_bar;
        fold_r <= 1'b0;
      end
      ST_MUL: begin
        prod_r <= 64'(tr_r.price) * 64'(tr_r.qty);
        if (valid_r[slot]) begin
          fold_r     <= (end_t >= {1'b0, tr_r.t});
          nb_begin_r <= TIME_W'(end_t + 1'b1);
        end
      end
      ST_ALIGN: if (div_done) nb_begin_r <= tr_r.t - TIME_W'(rem);
      default: ;
    endcase
  end

  // one result per written bar
  always_ff @(posedge clk) begin
    if (!rst_n) res_valid <= 1'b0;
    else res_valid <= we;
    if (we) begin
      res_period <= per_r;
      res_pair   <= tr_r.pair;
      res_bar    <= nb;
      res_new    <= newb;
    end
  end
endmodule

[hw/rtl/ohlc_bar_aggregator.sv]
// ohlc_bar_aggregator: top level, apb register file plus front and back parts
// depends on ohlc_pkg, ohlc_front, ohlc_back
//
// usage: raise start with a trade on in_pair_id, in_trade_price, in_trade_qty and
// in_trade_time while busy is low; the request is taken at that edge. a trade
// whose pair is out of range is dropped. each taken trade gives three results on
// the out_ ports, minute, hour, day, each marked by out_valid for one cycle,
// out_last on the day bar. a two-entry queue parts the input from the bar engine.
// each bar costs a ram read, a latch of the read data, a compare and multiply,
// and a write, plus a bit-serial remainder for alignment for each period whose
// bar is the first of its pair. the receiver cannot stall. reset clears the
// queue, the bar valid flags and the length registers to 60000, 3600000 and
// 86400000 ms. lengths sit at cfg byte addresses 0, 4, 8; the user must see that
// they are written only while idle, the block itself does not enforce it.
module ohlc_bar_aggregator import ohlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [5:0]  in_pair_id,
  input  logic [31:0] in_trade_price,
  input  logic [31:0] in_trade_qty,
  input  logic [47:0] in_trade_time,
  output logic        out_valid,
  output logic [1:0]  out_period,
  output logic [5:0]  out_pair_out,
  output logic [47:0] out_bar_start,
  output logic [31:0] out_open_price,
  output logic [31:0] out_high_price,
  output logic [31:0] out_low_price,
  output logic [31:0] out_close_price,
  output logic [63:0] out_amount,
  output logic [63:0] out_volume,
  output logic [31:0] out_trades_in_bar,
  output logic        out_new_bar,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] len_min_r, len_hour_r, len_day_r;
  logic        wr, q_valid, q_pop;
  logic [1:0]  ridx;
  trade_t      tr, q_data;
  bar_t        rb;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_min_r  <= MINUTE_RESET;
      len_hour_r <= HOUR_RESET;
      len_day_r  <= DAY_RESET;
    end else if (wr) begin
      case (ridx)
        REG_MINUTE: len_min_r  <= pwdata;
        REG_HOUR:   len_hour_r <= pwdata;
        REG_DAY:    len_day_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_MINUTE: prdata = len_min_r;
      REG_HOUR:   prdata = len_hour_r;
      REG_DAY:    prdata = len_day_r;
      default:    prdata = '0;
    endcase
  end

  assign tr = '{pair: in_pair_id, price: in_trade_price, qty: in_trade_qty, t: in_trade_time};

  ohlc_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .trade(tr), .busy(busy),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  ohlc_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .len_min(len_min_r), .len_hour(len_hour_r), .len_day(len_day_r),
    .res_valid(out_valid), .res_period(out_period), .res_pair(out_pair_out),
    .res_bar(rb), .res_new(out_new_bar)
  );

  assign out_bar_start     = rb.begin_t;
  assign out_open_price    = rb.open_p;
  assign out_high_price    = rb.high_p;
  assign out_low_price     = rb.low_p;
  assign out_close_price   = rb.close_p;
  assign out_amount        = rb.amount;
  assign out_volume        = rb.volume;
  assign out_trades_in_bar = rb.count;
  assign out_last          = (out_period == PER_DAY);

  a_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_period != 2'd3) else $error("bad period");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period != PER_DAY |=> !out_valid) else $error("results too close");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_bar |-> out_trades_in_bar == 32'd1) else $error("new bar count");
  a_hilo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_bar |-> out_high_price == out_low_price) else $error("new bar hi/lo");
endmodule
